FILE: src/decimal_text_to_integer_parser_core_macros.svh
// Assertion macros used by the parser top level.
`ifndef DECIMAL_TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTIP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dtip_pkg.sv
// Shared types and constants for the decimal text parser.
package dtip_pkg;

  localparam int unsigned MagW   = 64;
  localparam int unsigned PhaseW = 3;

  // parse phases
  localparam logic [PhaseW-1:0] PH_LEAD   = 3'd0;
  localparam logic [PhaseW-1:0] PH_SIGN   = 3'd1;
  localparam logic [PhaseW-1:0] PH_DIGITS = 3'd2;
  localparam logic [PhaseW-1:0] PH_TRAIL  = 3'd3;
  localparam logic [PhaseW-1:0] PH_FAIL   = 3'd4;

  localparam logic [MagW-1:0] LIMIT32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [MagW-1:0] LIMIT64 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              negative;
    logic [MagW-1:0]   magnitude;
  } state_t;

  typedef struct packed {
    logic [MagW-1:0] value;
    logic            ok;
  } result_t;

endpackage

FILE: src/decimal_text_to_integer_parser_core.sv
// Decimal text parser top level: parses one signed decimal integer per string of characters.
//
// Input channel: one text byte per transfer on ch_i, with has_char_i (0 only for an
// item that carries no character) and last_i marking the final item of a string.
// Output channel: one transfer per string, issued for the item marked last, with
// value_o (signed, sign-extended in 32-bit mode, 0 on failure) and ok_o.
// cfg_we_i/cfg_wdata_i write width_mode (0: 32-bit range, 1: 64-bit range); write
// only while no string is in flight.
// The last item of a string is held in the input register, then its result is held
// in the result register. Throughput: one item per cycle while no last item waits
// behind a stalled result; the per-item path is a multiply by ten (shift-add), an add
// and a 68-bit range compare feeding back into the parse state.
// Reset: clears the input and result stages, returns the parser to the leading
// whitespace phase and sets width_mode to 1.
// Stall: a held result stays on the output; characters that produce no result keep
// being consumed, and in_stall_o rises only once a last item is waiting behind an
// unaccepted result.
`include "decimal_text_to_integer_parser_core_macros.svh"

module decimal_text_to_integer_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        has_char_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [63:0] value_o,
  output logic        ok_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic               width_mode_q;
  logic               item_valid;
  dtip_pkg::item_t    item;
  logic               advance;
  dtip_pkg::state_t   state_q, state_d;
  dtip_pkg::result_t  result;
  logic               out_valid_q, out_valid_d;
  dtip_pkg::result_t  out_q;

  // a last item may only move on when the result register is free or draining
  assign advance = item_valid && (!item.last || !out_valid_q || !out_stall_i);

  dtip_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .ch_i         (ch_i),
    .has_char_i   (has_char_i),
    .last_i       (last_i),
    .advance_i    (advance),
    .in_stall_o   (in_stall_o),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dtip_step u_step (
    .width_mode_i (width_mode_q),
    .state_i      (state_q),
    .item_i       (item),
    .state_o      (state_d),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      width_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= dtip_pkg::PH_LEAD;
      state_q.negative  <= 1'b0;
      state_q.magnitude <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && item.last) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item.last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(out_q.value);
  assign ok_o        = out_q.ok;

  `DTIP_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_o && !ok_o, value_o == 64'sd0, "failed parse must report zero")
  `DTIP_ASSERT_IMPL(a_stall_holds_item, clk_i, rst_ni, in_stall_o, item_valid && item.last && out_valid_q && out_stall_i, "stall without a blocked last item")
  `DTIP_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, advance && item.last, state_q.phase == dtip_pkg::PH_LEAD && !state_q.negative && state_q.magnitude == '0, "state not cleared after string end")
  `DTIP_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, advance && item.last, out_valid_q, "result register not loaded on string end")

endmodule

FILE: src/dtip_in_stage.sv
// Input register stage: holds one accepted character until the parser consumes it.
module dtip_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         ch_i,
  input  logic               has_char_i,
  input  logic               last_i,
  input  logic               advance_i,
  output logic               in_stall_o,
  output logic               item_valid_o,
  output dtip_pkg::item_t    item_o
);

  logic            valid_q, valid_d;
  logic            load;
  dtip_pkg::item_t item_q;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.ch       <= ch_i;
      item_q.has_char <= has_char_i;
      item_q.last     <= last_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: src/dtip_step.sv
// Per-character parse step: phase update, digit accumulate with range check, final report.
module dtip_step (
  input  logic               width_mode_i,
  input  dtip_pkg::state_t   state_i,
  input  dtip_pkg::item_t    item_i,
  output dtip_pkg::state_t   state_o,
  output dtip_pkg::result_t  result_o
);

  logic [dtip_pkg::MagW-1:0] lim_base;
  logic [dtip_pkg::MagW-1:0] lim_cur;
  logic [dtip_pkg::MagW-1:0] lim_end;
  logic [dtip_pkg::MagW+3:0] prod;
  logic [3:0]                digit;
  logic                      is_space;
  logic                      is_digit;
  logic                      digit_ovf;
  logic                      good;
  dtip_pkg::state_t          nxt;

  always_comb begin
    lim_base = width_mode_i ? dtip_pkg::LIMIT64 : dtip_pkg::LIMIT32;
    lim_cur  = lim_base + {63'd0, state_i.negative};
    is_space = (item_i.ch == dtip_pkg::CH_SPACE) ||
               (item_i.ch >= dtip_pkg::CH_TAB && item_i.ch <= dtip_pkg::CH_CR);
    is_digit = (item_i.ch >= dtip_pkg::CH_ZERO) && (item_i.ch <= dtip_pkg::CH_NINE);
    digit    = 4'(item_i.ch - dtip_pkg::CH_ZERO);
    // m*10 + d, kept wide so the compare sees any overflow past 64 bits
    prod      = {1'b0, state_i.magnitude, 3'b000} + {3'b000, state_i.magnitude, 1'b0} +
                {64'd0, digit};
    digit_ovf = prod > {4'd0, lim_cur};

    nxt = state_i;
    if (item_i.has_char) begin
      case (state_i.phase)
        dtip_pkg::PH_LEAD: begin
          if (is_space) begin
            nxt.phase = dtip_pkg::PH_LEAD;
          end else if (item_i.ch == dtip_pkg::CH_MINUS) begin
            nxt.negative = 1'b1;
            nxt.phase    = dtip_pkg::PH_SIGN;
          end else if (is_digit) begin
            if (digit_ovf) begin
              nxt.phase = dtip_pkg::PH_FAIL;
            end else begin
              nxt.magnitude = prod[dtip_pkg::MagW-1:0];
              nxt.phase     = dtip_pkg::PH_DIGITS;
            end
          end else begin
            nxt.phase = dtip_pkg::PH_FAIL;
          end
        end
        dtip_pkg::PH_SIGN, dtip_pkg::PH_DIGITS: begin
          if (is_digit) begin
            if (digit_ovf) begin
              nxt.phase = dtip_pkg::PH_FAIL;
            end else begin
              nxt.magnitude = prod[dtip_pkg::MagW-1:0];
              nxt.phase     = dtip_pkg::PH_DIGITS;
            end
          end else if (is_space && state_i.phase == dtip_pkg::PH_DIGITS) begin
            nxt.phase = dtip_pkg::PH_TRAIL;
          end else begin
            nxt.phase = dtip_pkg::PH_FAIL;
          end
        end
        dtip_pkg::PH_TRAIL: begin
          if (!is_space) begin
            nxt.phase = dtip_pkg::PH_FAIL;
          end
        end
        default: begin
          nxt.phase = dtip_pkg::PH_FAIL;
        end
      endcase
    end

    // range is checked again at the end against the width then in force
    lim_end = lim_base + {63'd0, nxt.negative};
    good    = (nxt.phase == dtip_pkg::PH_DIGITS || nxt.phase == dtip_pkg::PH_TRAIL) &&
              (nxt.magnitude <= lim_end);
    result_o.ok    = good;
    result_o.value = !good ? '0 :
                     (nxt.negative ? (64'd0 - nxt.magnitude) : nxt.magnitude);

    state_o = nxt;
    if (item_i.last) begin
      state_o.phase     = dtip_pkg::PH_LEAD;
      state_o.negative  = 1'b0;
      state_o.magnitude = '0;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the decimal text to integer parser core.
module testbench;

  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CHUNK_ITEMS  = 150;

  // directed stimulus: one text byte per row, expectation typed in where obvious
  typedef struct packed {
    logic [7:0]  ch;
    logic        has_char;
    logic        last;
    logic        typed;
    logic [63:0] value;
    logic        ok;
  } text_row_t;

  localparam text_row_t DIRECTED [23] = '{
    '{8'h00,              1'b0, 1'b1, 1'b1, 64'd0, 1'b0},  // empty string
    '{dtip_pkg::CH_ZERO,  1'b1, 1'b1, 1'b1, 64'd0, 1'b1},
    '{dtip_pkg::CH_MINUS, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{dtip_pkg::CH_ZERO,  1'b1, 1'b1, 1'b1, 64'd0, 1'b1},  // minus zero
    '{8'h2B,              1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{8'h31,              1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // plus sign rejected
    '{dtip_pkg::CH_MINUS, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{dtip_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{8'h35,              1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // space after minus
    '{dtip_pkg::CH_TAB,   1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{8'h37,              1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{dtip_pkg::CH_CR,    1'b1, 1'b1, 1'b0, 64'd0, 1'b0},
    '{8'hFF,              1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // high byte
    '{8'h00,              1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // NUL
    '{dtip_pkg::CH_MINUS, 1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // bare minus
    '{8'h0B,              1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // whitespace only
    '{dtip_pkg::CH_NINE,  1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{8'h61,              1'b1, 1'b1, 1'b1, 64'd0, 1'b0},  // letter after digit
    '{8'h33,              1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{8'h00,              1'b0, 1'b1, 1'b0, 64'd0, 1'b0},  // empty item closes string
    '{dtip_pkg::CH_MINUS, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{dtip_pkg::CH_NINE,  1'b1, 1'b0, 1'b0, 64'd0, 1'b0},
    '{8'h0C,              1'b1, 1'b1, 1'b0, 64'd0, 1'b0}
  };

  localparam logic WIDTH_PLAN [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
  localparam int unsigned SEND_GAP [3] = '{7, 52, 0};
  localparam int unsigned RECV_GAP [3] = '{52, 7, 0};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         ch_i;
  logic               has_char_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [63:0] value_o;
  logic               ok_o;
  logic               cfg_we_i;
  logic               cfg_wdata_i;

  // parser mirror
  logic [dtip_pkg::PhaseW-1:0] mirror_phase;
  logic                        mirror_neg;
  logic [63:0]                 mirror_mag;
  logic                        mirror_wide;

  dtip_pkg::result_t parsed_q[$];
  dtip_pkg::item_t   text_q[$];
  int unsigned       send_gap_pct;
  int unsigned       recv_gap_pct;
  int unsigned       fail_count = 0;
  int unsigned       stuck_cycles = 0;

  decimal_text_to_integer_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .ok_o        (ok_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == dtip_pkg::CH_SPACE || (c >= dtip_pkg::CH_TAB && c <= dtip_pkg::CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= dtip_pkg::CH_ZERO && c <= dtip_pkg::CH_NINE;
  endfunction

  // negative values may reach one past the positive limit
  function automatic logic [63:0] mag_limit();
    logic [63:0] lim;
    lim = mirror_wide ? dtip_pkg::LIMIT64 : dtip_pkg::LIMIT32;
    return mirror_neg ? lim + 64'd1 : lim;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - dtip_pkg::CH_ZERO};
    if (mirror_mag > (mag_limit() - d) / 64'd10) begin
      mirror_phase = dtip_pkg::PH_FAIL;
    end else begin
      mirror_mag   = mirror_mag * 64'd10 + d;
      mirror_phase = dtip_pkg::PH_DIGITS;
    end
  endfunction

  function automatic void parse_char(logic [7:0] c);
    case (mirror_phase)
      dtip_pkg::PH_LEAD: begin
        if (is_blank(c)) begin
        end else if (c == dtip_pkg::CH_MINUS) begin
          mirror_neg   = 1'b1;
          mirror_phase = dtip_pkg::PH_SIGN;
        end else if (is_digit(c)) begin
          take_digit(c);
        end else begin
          mirror_phase = dtip_pkg::PH_FAIL;
        end
      end
      dtip_pkg::PH_SIGN: begin
        if (is_digit(c)) take_digit(c);
        else mirror_phase = dtip_pkg::PH_FAIL;
      end
      dtip_pkg::PH_DIGITS: begin
        if (is_digit(c)) take_digit(c);
        else if (is_blank(c)) mirror_phase = dtip_pkg::PH_TRAIL;
        else mirror_phase = dtip_pkg::PH_FAIL;
      end
      dtip_pkg::PH_TRAIL: begin
        if (!is_blank(c)) mirror_phase = dtip_pkg::PH_FAIL;
      end
      default: mirror_phase = dtip_pkg::PH_FAIL;
    endcase
  endfunction

  function automatic void parse_item(dtip_pkg::item_t it);
    dtip_pkg::result_t r;
    if (it.has_char) parse_char(it.ch);
    if (it.last) begin
      r.ok    = (mirror_phase == dtip_pkg::PH_DIGITS || mirror_phase == dtip_pkg::PH_TRAIL) &&
                mirror_mag <= mag_limit();
      r.value = r.ok ? (mirror_neg ? 64'd0 - mirror_mag : mirror_mag) : 64'd0;
      parsed_q.push_back(r);
      mirror_phase = dtip_pkg::PH_LEAD;
      mirror_neg   = 1'b0;
      mirror_mag   = 64'd0;
    end
  endfunction

  task automatic send_item(input dtip_pkg::item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= it.ch;
    has_char_i <= it.has_char;
    last_i     <= it.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_item(it);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (parsed_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_width(input logic wide);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wide;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror_wide = wide;
  endtask

  // occasionally slips an ignored empty item in front of a character
  function automatic void add_byte(logic [7:0] c);
    dtip_pkg::item_t it;
    if ($urandom_range(19) == 0) begin
      it = '{ch: 8'($urandom_range(255)), has_char: 1'b0, last: 1'b0};
      text_q.push_back(it);
    end
    it = '{ch: c, has_char: 1'b1, last: 1'b0};
    text_q.push_back(it);
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] s;
    s = 8'($urandom_range(dtip_pkg::CH_TAB, dtip_pkg::CH_CR));
    return $urandom_range(1) ? dtip_pkg::CH_SPACE : s;
  endfunction

  function automatic void build_text();
    logic [63:0]     mag;
    string           digits;
    int unsigned     pick;
    int unsigned     kind;
    int unsigned     idx;
    dtip_pkg::item_t it;
    text_q.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
    end else if (pick < 12) begin
      // sign and blanks without digits
      repeat ($urandom_range(0, 2)) add_byte(blank_char());
      if ($urandom_range(1)) add_byte(dtip_pkg::CH_MINUS);
      repeat ($urandom_range(0, 1)) add_byte(blank_char());
    end else begin
      kind = $urandom_range(4);
      repeat ($urandom_range(0, 2)) add_byte(blank_char());
      if ($urandom_range(1)) add_byte(dtip_pkg::CH_MINUS);
      case (kind)
        0:       mag = 64'($urandom_range(99999));
        1:       mag = {$urandom, $urandom} >> $urandom_range(63);
        2:       mag = dtip_pkg::LIMIT32 - 64'd2 + 64'($urandom_range(4));
        3:       mag = dtip_pkg::LIMIT64 - 64'd2 + 64'($urandom_range(4));
        default: mag = {$urandom, $urandom};
      endcase
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) add_byte(dtip_pkg::CH_ZERO);
      digits = $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++) add_byte(digits[i]);
      // extra digits make the value larger, usually past the range
      if (kind == 4) begin
        repeat ($urandom_range(1, 2)) add_byte(dtip_pkg::CH_ZERO + 8'($urandom_range(9)));
      end
      repeat ($urandom_range(0, 2)) add_byte(blank_char());
      if (pick < 30) begin
        idx = $urandom_range(text_q.size() - 1);
        it = text_q[idx];
        it.ch = 8'($urandom_range(255));
        text_q[idx] = it;
      end
    end
    if (text_q.size() == 0 || $urandom_range(7) == 0) begin
      it = '{ch: 8'($urandom_range(255)), has_char: 1'b0, last: 1'b1};
      text_q.push_back(it);
    end else begin
      it = text_q[text_q.size() - 1];
      it.last = 1'b1;
      text_q[text_q.size() - 1] = it;
    end
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_gap_pct);
  end

  always @(posedge clk_i) begin
    dtip_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parsed_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: value %0d ok %0b", value_o, ok_o);
        fail_count++;
      end else begin
        want = parsed_q.pop_front();
        if (value_o !== want.value || ok_o !== want.ok) begin
          if (fail_count < 10)
            $display("result mismatch: value %0d ok %0b, expected value %0d ok %0b",
                     value_o, ok_o, $signed(want.value), want.ok);
          fail_count++;
        end
      end
    end
  end

  // no transfer for too long means the block hung
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("decimal_text_to_integer_parser_core test failed");
      $finish;
    end
  end

  initial begin
    dtip_pkg::item_t it;
    int unsigned     counted;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    ch_i         = 8'd0;
    has_char_i   = 1'b0;
    last_i       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    mirror_phase = dtip_pkg::PH_LEAD;
    mirror_neg   = 1'b0;
    mirror_mag   = 64'd0;
    mirror_wide  = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gap_pct <= SEND_GAP[0];
    recv_gap_pct <= RECV_GAP[0];
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      it = '{ch: DIRECTED[r].ch, has_char: DIRECTED[r].has_char, last: DIRECTED[r].last};
      send_item(it);
      if (DIRECTED[r].last && DIRECTED[r].typed) begin
        void'(parsed_q.pop_back());
        parsed_q.push_back(dtip_pkg::result_t'{value: DIRECTED[r].value, ok: DIRECTED[r].ok});
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct <= SEND_GAP[ph];
      recv_gap_pct <= RECV_GAP[ph];
      for (int half = 0; half < 2; half++) begin
        set_width(WIDTH_PLAN[ph * 2 + half]);
        counted = 0;
        while (counted < CHUNK_ITEMS) begin
          if ($urandom_range(29) == 0) hold_until_drained();
          build_text();
          foreach (text_q[k]) begin
            send_item(text_q[k]);
            if (text_q[k].has_char || text_q[k].last) counted++;
          end
        end
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && parsed_q.size() == 0) begin
      $display("decimal_text_to_integer_parser_core test passed");
    end else begin
      $display("decimal_text_to_integer_parser_core test failed");
    end
    $finish;
  end

endmodule
